### src/bsfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver package
// Shared types, codes and the byte-wide CRC-16/X.25 update.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  localparam logic [7:0]  FlagReset   = 8'h7E;
  localparam logic [7:0]  EscapeReset = 8'h7D;
  localparam logic [7:0]  StuffMask   = 8'h20;
  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPoly     = 16'h8408;
  localparam logic [15:0] CrcGood     = 16'hF0B8;

  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  // Register indexes, taken from byte address bit 2.
  localparam logic RegFlag   = 1'b0;
  localparam logic RegEscape = 1'b1;

  typedef enum logic [1:0] {
    ModeIdle   = 2'd0,
    ModeStart  = 2'd1,
    ModeData   = 2'd2,
    ModeEscape = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    TimerNone  = 2'd0,
    TimerStart = 2'd1,
    TimerStop  = 2'd2
  } timer_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timeout_seen;
  } rx_item_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       frame_good;
    logic       frame_abort;
    logic [1:0] timer_control;
  } rx_result_t;

  // One byte through the reflected CRC-16/X.25, least significant bit first.
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### src/byte_stuffed_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver
// Removes byte stuffing from a received serial stream, checks the CRC-16/X.25
// of each frame and reports frame end, abort and timer requests.
//
// Input channel: one request carries a received byte and a timeout flag; it is
// taken when in_valid_i is high and in_stall_o is low. Output channel: every
// input request gives exactly one result request, taken when out_valid_o is
// high and out_stall_i is low. The flag and escape bytes are set through the
// APB-style port (flag at byte address 0, escape at 4) only while the block
// idles, a rule for the user that the block itself does not enforce. Results
// are registered. Throughput is one byte per cycle while in_stall_o is low,
// set by the single mode and CRC register update that each byte needs.
// Reset empties the output stages, returns the receiver to idle, presets the
// CRC to 0xFFFF and the flag and escape bytes to 0x7E and 0x7D.
// When the receiver stalls, the held result stays on the outputs and one more
// result goes into a skid stage; in_stall_o rises only while that is full.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bsfr_pkg::rx_item_t                  in_data_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bsfr_pkg::rx_result_t                out_data_o,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bsfr_pkg::AddrWidth-1:0]      paddr,
  input  logic [bsfr_pkg::DataWidth-1:0]      pwdata,
  output logic [bsfr_pkg::DataWidth-1:0]      prdata,
  output logic                                pready
);
  import bsfr_pkg::*;

  // Configuration registers.
  logic [7:0] flag_q;
  logic [7:0] escape_q;
  logic       cfg_write;

  // Receiver state.
  mode_e       mode_q, mode_d;
  logic [15:0] crc_q, crc_d;

  // Output register and skid stage.
  logic       out_valid_q;
  logic       skid_valid_q;
  rx_result_t out_q;
  rx_result_t skid_q;
  rx_result_t result;

  logic in_acc;
  logic out_free;
  logic is_flag;
  logic is_escape;

  // ---------------------------------------------------------------------------
  // Configuration port. pready is always high, so each write completes in its
  // access cycle. Only bit 2 of the address selects a register.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q   <= FlagReset;
      escape_q <= EscapeReset;
    end else if (cfg_write) begin
      case (paddr[2])
        RegFlag:   flag_q   <= pwdata[7:0];
        RegEscape: escape_q <= pwdata[7:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegFlag:   prdata = {{(DataWidth-8){1'b0}}, flag_q};
      RegEscape: prdata = {{(DataWidth-8){1'b0}}, escape_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake. The skid stage takes a result when the output register is held,
  // so a new byte is refused only while the skid stage is occupied.
  // ---------------------------------------------------------------------------
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Receive mode and result for the byte on the input. The escape byte is
  // tested before the flag in data mode, and the flag before the timeout in
  // start mode; this order also settles a flag byte equal to the escape byte.
  // ---------------------------------------------------------------------------
  assign is_flag   = (in_data_i.rx_byte == flag_q);
  assign is_escape = (in_data_i.rx_byte == escape_q);

  always_comb begin
    mode_d = mode_q;
    crc_d  = crc_q;
    result = '0;
    result.timer_control = TimerNone;
    case (mode_q)
      ModeIdle: begin
        if (is_flag) begin
          result.timer_control = TimerStart;
          crc_d  = CrcInit;
          mode_d = ModeStart;
        end else begin
          result.timer_control = TimerStop;
        end
      end
      ModeStart: begin
        if (is_flag) begin
          mode_d = ModeStart;
        end else if (in_data_i.timeout_seen) begin
          result.timer_control = TimerStop;
          result.frame_abort   = 1'b1;
          mode_d = ModeIdle;
        end else if (is_escape) begin
          mode_d = ModeEscape;
        end else begin
          result.data_valid = 1'b1;
          result.data_byte  = in_data_i.rx_byte;
          crc_d  = crc_feed(crc_q, in_data_i.rx_byte);
          mode_d = ModeData;
        end
      end
      ModeData: begin
        if (is_escape) begin
          mode_d = ModeEscape;
        end else if (is_flag) begin
          result.timer_control = TimerStop;
          result.frame_end     = 1'b1;
          result.frame_good    = (crc_q == CrcGood);
          mode_d = ModeIdle;
        end else if (in_data_i.timeout_seen) begin
          result.timer_control = TimerStop;
          result.frame_abort   = 1'b1;
          mode_d = ModeIdle;
        end else begin
          result.data_valid = 1'b1;
          result.data_byte  = in_data_i.rx_byte;
          crc_d = crc_feed(crc_q, in_data_i.rx_byte);
        end
      end
      ModeEscape: begin
        if (in_data_i.timeout_seen || is_escape || is_flag) begin
          result.timer_control = TimerStop;
          result.frame_abort   = 1'b1;
          mode_d = ModeIdle;
        end else begin
          result.data_valid = 1'b1;
          result.data_byte  = in_data_i.rx_byte ^ StuffMask;
          crc_d  = crc_feed(crc_q, in_data_i.rx_byte ^ StuffMask);
          mode_d = ModeData;
        end
      end
      default: begin
        mode_d = ModeIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      crc_q  <= CrcInit;
    end else if (in_acc) begin
      mode_q <= mode_d;
      crc_q  <= crc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with a one-entry skid stage behind it. Results leave in
  // the order their bytes arrived: the skid entry always drains first.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= result;
      end
    end else if (in_acc) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // The skid stage only fills behind a held output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage occupied while output register is empty");

  // A result never carries a data byte together with a frame event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.data_valid && (out_q.frame_end || out_q.frame_abort)))
    else $error("data byte reported together with frame end or abort");

  // A good frame is only reported on a frame end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_good) |-> out_q.frame_end)
    else $error("frame good without frame end");

  // An opening flag presets the CRC.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_q == ModeIdle && is_flag) |=> (crc_q == CrcInit && mode_q == ModeStart))
    else $error("opening flag did not preset the CRC");

  // Any other byte in idle keeps the receiver idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_q == ModeIdle && !is_flag) |=> (mode_q == ModeIdle))
    else $error("receiver left idle without a flag");
`endif

endmodule
